// ===== sv/som_prototype_node_unit_macros.svh =====
// Assertion macros shared by the checker of the prototype node.
// Each expects signals named clock and reset where it is used.
`ifndef SOM_PROTOTYPE_NODE_UNIT_MACROS_SVH
`define SOM_PROTOTYPE_NODE_UNIT_MACROS_SVH

// Same-cycle implication, switched off during reset.
`define SOM_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("prototype node check failed");

// Next-cycle implication, switched off during reset.
`define SOM_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("prototype node check failed");

`endif

// ===== sv/som_pkg.sv =====
`timescale 1ns / 1ps

package som_pkg;

   // Sizes of the request and result fields.
   localparam int MAX_DIM_DEF  = 64;
   localparam int ELEMENT_BITS = 16;
   localparam int INDEX_BITS   = 6;
   localparam int VLEN_BITS    = 7;
   localparam int WEIGHT_BITS  = 17;
   localparam int DIST_BITS    = 19;
   localparam int COUNT_BITS   = 32;

   // Internal arithmetic widths.
   localparam int DIFF_BITS    = ELEMENT_BITS + 1;
   localparam int OPND_BITS    = DIFF_BITS + 1;
   localparam int PROD_BITS    = 2 * OPND_BITS;
   localparam int SQ_BITS      = 2 * ELEMENT_BITS + 1;
   localparam int SUM_BITS     = 40;
   localparam int ROOT_BITS    = SUM_BITS / 2;
   localparam int STEP_BITS    = PROD_BITS - 16;

   localparam logic [VLEN_BITS-1:0]   VLEN_RESET = 7'd64;
   localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = 17'h10000;

   // Depth of the queue between front end and back end.
   localparam int QUEUE_DEPTH  = 2;

   typedef enum logic [1:0] {
      CMD_LOAD   = 2'd0,
      CMD_DIST   = 2'd1,
      CMD_UPDATE = 2'd2,
      CMD_COUNT  = 2'd3
   } som_cmd_type;

   typedef enum logic {
      KIND_DIST  = 1'b0,
      KIND_COUNT = 1'b1
   } som_kind_type;

   typedef struct packed {
      logic [1:0]                     command;
      logic [INDEX_BITS-1:0]          element_index;
      logic signed [ELEMENT_BITS-1:0] element_value;
      logic [WEIGHT_BITS-1:0]         weight;
      logic                           last;
   } som_req_type;

   typedef struct packed {
      logic                  kind;
      logic [DIST_BITS-1:0]  distance;
      logic [COUNT_BITS-1:0] match_count;
   } som_rsp_type;

   // A classified request as it waits in the queue.
   typedef struct packed {
      som_cmd_type                    command;
      logic [INDEX_BITS-1:0]          index;
      logic                           in_use;
      logic signed [ELEMENT_BITS-1:0] value;
      logic [WEIGHT_BITS-1:0]         weight;
      logic                           last;
   } som_op_type;

endpackage

// ===== sv/som_front.sv =====
`timescale 1ns / 1ps

module som_front #(
   parameter int MAX_DIM = som_pkg::MAX_DIM_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [som_pkg::VLEN_BITS-1:0]   csr_wr_data,
   input  logic                            push,
   input  som_pkg::som_req_type            req_data,
   input  logic                            q_full,
   output logic                            q_push,
   output som_pkg::som_op_type             op
);

   logic [som_pkg::VLEN_BITS-1:0] vlen_ff;
   logic                          idx_below_len;
   logic                          idx_below_dim;

   // Vector length register.
   always_ff @(posedge clock) begin
      if (reset) begin
         vlen_ff <= som_pkg::VLEN_RESET;
      end else if (csr_wr_en) begin
         vlen_ff <= csr_wr_data;
      end
   end

   // An index counts only below both the programmed length and the store depth.
   assign idx_below_len = {1'b0, req_data.element_index} < vlen_ff;
   assign idx_below_dim = 32'(req_data.element_index) < 32'(MAX_DIM);

   // Classify the request and clamp the weight to one.
   always_comb begin
      op.command = som_pkg::som_cmd_type'(req_data.command);
      op.index   = req_data.element_index;
      op.in_use  = idx_below_len && idx_below_dim;
      op.value   = req_data.element_value;
      op.weight  = (req_data.weight > som_pkg::WEIGHT_ONE) ? som_pkg::WEIGHT_ONE
                                                           : req_data.weight;
      op.last    = req_data.last;
   end

   assign q_push = push && !q_full;

endmodule

// ===== sv/som_queue.sv =====
`timescale 1ns / 1ps

module som_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  som_pkg::som_op_type din,
   input  logic                pop,
   output som_pkg::som_op_type dout,
   output logic                full,
   output logic                empty
);

   localparam int PTR_W = (som_pkg::QUEUE_DEPTH > 1) ? $clog2(som_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(som_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(som_pkg::QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(som_pkg::QUEUE_DEPTH);

   som_pkg::som_op_type slot_ff [som_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff;
   logic [PTR_W-1:0]    rd_ptr_ff;
   logic [CNT_W-1:0]    count_ff;
   logic                do_push;
   logic                do_pop;

   assign full    = (count_ff == DEPTH_CNT);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = slot_ff[rd_ptr_ff];

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= din;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== sv/som_isqrt.sv =====
`timescale 1ns / 1ps

module som_isqrt (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [som_pkg::SUM_BITS-1:0]    operand,
   output logic [som_pkg::ROOT_BITS-1:0]   root,
   output logic                            done
);

   localparam int REM_W = som_pkg::ROOT_BITS + 2;
   localparam int CNT_W = $clog2(som_pkg::ROOT_BITS);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(som_pkg::ROOT_BITS - 1);

   logic [som_pkg::SUM_BITS-1:0]  rad_ff;
   logic [REM_W-1:0]              rem_ff;
   logic [som_pkg::ROOT_BITS-1:0] root_ff;
   logic [CNT_W-1:0]              cnt_ff;
   logic                          busy_ff;
   logic                          done_ff;
   logic [REM_W-1:0]              rem_sh;
   logic [REM_W-1:0]              trial;
   logic                          fits;

   // One result bit per cycle: bring down two radicand bits and try the next digit.
   assign rem_sh = {rem_ff[REM_W-3:0], rad_ff[som_pkg::SUM_BITS-1 -: 2]};
   assign trial  = {root_ff, 2'b01};
   assign fits   = rem_sh >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= operand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[som_pkg::SUM_BITS-3:0], 2'b00};
         rem_ff  <= fits ? rem_sh - trial : rem_sh;
         root_ff <= {root_ff[som_pkg::ROOT_BITS-2:0], fits};
      end
   end

   assign root = root_ff;
   assign done = done_ff;

endmodule

// ===== sv/som_back.sv =====
`timescale 1ns / 1ps

module som_back #(
   parameter int MAX_DIM = som_pkg::MAX_DIM_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  som_pkg::som_op_type  head,
   input  logic                 q_empty,
   output logic                 q_pop,
   output som_pkg::som_rsp_type rsp_data,
   output logic                 rsp_empty,
   input  logic                 rsp_pop
);

   localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int EB = som_pkg::ELEMENT_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_ACC,
      ST_ROOT,
      ST_OUT
   } state_type;

   state_type                            state_ff, state_in;
   som_pkg::som_op_type                  op_ff, op_in;
   logic signed [som_pkg::PROD_BITS-1:0] mul_ff, mul_in;
   logic [som_pkg::SUM_BITS-1:0]         sum_ff, sum_in;
   logic [som_pkg::COUNT_BITS-1:0]       win_ff, win_in;
   som_pkg::som_rsp_type                 pend_ff, pend_in;
   som_pkg::som_rsp_type                 rsp_ff, rsp_in;
   logic                                 rsp_valid_ff, rsp_valid_in;

   logic signed [EB-1:0]                 mem [MAX_DIM];
   logic signed [EB-1:0]                 proto_ff;
   logic                                 wr_en;
   logic [AW-1:0]                        wr_addr;
   logic signed [EB-1:0]                 wr_data;

   logic signed [som_pkg::DIFF_BITS-1:0] diff;
   logic signed [som_pkg::OPND_BITS-1:0] mul_a;
   logic signed [som_pkg::OPND_BITS-1:0] mul_b;
   logic [som_pkg::SQ_BITS-1:0]          sq;
   logic [som_pkg::SUM_BITS:0]           sum_add;
   logic [som_pkg::SUM_BITS-1:0]         sum_sat;
   logic signed [som_pkg::STEP_BITS-1:0] step;
   logic signed [som_pkg::STEP_BITS-1:0] moved;
   logic                                 root_start;
   logic [som_pkg::ROOT_BITS-1:0]        root;
   logic                                 root_done;
   logic                                 out_free;

   som_isqrt u_isqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (root_start),
      .operand (sum_sat),
      .root    (root),
      .done    (root_done)
   );

   // Prototype store: one write port, registered read at the queue head while idle,
   // so the element stays in place for the whole request.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (state_ff == ST_IDLE) begin
         proto_ff <= mem[AW'(head.index)];
      end
   end

   // Shared arithmetic: the difference feeds a square or a weighted step.
   always_comb begin
      diff  = {op_ff.value[EB-1], op_ff.value} - {proto_ff[EB-1], proto_ff};
      mul_b = {diff[som_pkg::DIFF_BITS-1], diff};
      if (op_ff.command == som_pkg::CMD_UPDATE) begin
         mul_a = signed'({1'b0, op_ff.weight});
      end else begin
         mul_a = mul_b;
      end
      sq      = op_ff.in_use ? mul_ff[som_pkg::SQ_BITS-1:0] : '0;
      sum_add = {1'b0, sum_ff} + (som_pkg::SUM_BITS + 1)'(sq);
      sum_sat = sum_add[som_pkg::SUM_BITS] ? '1 : sum_add[som_pkg::SUM_BITS-1:0];
      // Arithmetic shift by sixteen rounds the step toward minus infinity.
      step    = mul_ff[som_pkg::PROD_BITS-1:16];
      moved   = som_pkg::STEP_BITS'(proto_ff) + step;
   end

   assign out_free = !rsp_valid_ff || rsp_pop;

   // Sequencer for one request at a time.
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      mul_in     = mul_ff;
      sum_in     = sum_ff;
      win_in     = win_ff;
      pend_in    = pend_ff;
      rsp_in     = rsp_ff;
      q_pop      = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = AW'(head.index);
      wr_data    = head.value;
      root_start = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;

      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               op_in = head;
               if (head.command == som_pkg::CMD_LOAD) begin
                  wr_en = head.in_use;
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end
         ST_EXEC: begin
            mul_in = mul_a * mul_b;
            if (op_ff.command == som_pkg::CMD_COUNT) begin
               win_in = (win_ff == '1) ? win_ff : win_ff + 1'b1;
               pend_in.kind        = som_pkg::KIND_COUNT;
               pend_in.distance    = '0;
               pend_in.match_count = win_in;
               state_in = ST_OUT;
            end else begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            if (op_ff.command == som_pkg::CMD_UPDATE) begin
               wr_en    = op_ff.in_use;
               wr_addr  = AW'(op_ff.index);
               wr_data  = moved[EB-1:0];
               state_in = ST_IDLE;
            end else if (op_ff.last) begin
               root_start = 1'b1;
               sum_in     = '0;
               state_in   = ST_ROOT;
            end else begin
               sum_in   = sum_sat;
               state_in = ST_IDLE;
            end
         end
         ST_ROOT: begin
            if (root_done) begin
               pend_in.kind        = som_pkg::KIND_DIST;
               pend_in.distance    = root[som_pkg::ROOT_BITS-1] ? '1
                                     : root[som_pkg::DIST_BITS-1:0];
               pend_in.match_count = '0;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_in       = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, accumulators and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         win_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         win_ff       <= win_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff   <= op_in;
      mul_ff  <= mul_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_data  = rsp_ff;
   assign rsp_empty = !rsp_valid_ff;

endmodule

// ===== sv/som_prototype_node_unit.sv =====
`timescale 1ns / 1ps
// Channel    Ports                              Direction
// request    push, full, req_data               in
// result     empty, pop, rsp_data               out
// register   csr_wr_en, csr_wr_data             in
//
// Requests are taken into a two-entry queue; the back end runs one at a time.
// A load only writes the store; update and non-final distance elements pass execute and
// accumulate; count passes execute and output, with any wait for the result register; a
// final distance element adds the twenty steps of the square-root unit and that wait.
// Reset is synchronous and leaves the queue empty, the sum and win count zero and the length at 64.
// A held result stalls only the back end; requests still queue until full.
module som_prototype_node_unit #(
   parameter int MAX_DIM = som_pkg::MAX_DIM_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [som_pkg::VLEN_BITS-1:0]   csr_wr_data,
   input  logic                            push,
   output logic                            full,
   input  som_pkg::som_req_type            req_data,
   output logic                            empty,
   input  logic                            pop,
   output som_pkg::som_rsp_type            rsp_data
);

   logic                q_push;
   logic                q_pop;
   logic                q_full;
   logic                q_empty;
   som_pkg::som_op_type q_din;
   som_pkg::som_op_type q_dout;

   // Front end: register port and request classification.
   som_front #(
      .MAX_DIM (MAX_DIM)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .push        (push),
      .req_data    (req_data),
      .q_full      (q_full),
      .q_push      (q_push),
      .op          (q_din)
   );

   // Queue between the two halves.
   som_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (q_din),
      .pop   (q_pop),
      .dout  (q_dout),
      .full  (q_full),
      .empty (q_empty)
   );

   // Back end: prototype store, arithmetic and result register.
   som_back #(
      .MAX_DIM (MAX_DIM)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (q_dout),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_data  (rsp_data),
      .rsp_empty (empty),
      .rsp_pop   (pop)
   );

   assign full = q_full;

endmodule

// ===== sv/som_checker.sv =====
`timescale 1ns / 1ps
`include "som_prototype_node_unit_macros.svh"

module som_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          push,
   input logic                          full,
   input logic                          empty,
   input logic                          pop,
   input som_pkg::som_rsp_type          rsp_data
);

   // A waiting result stays put until it is taken.
   `SOM_ASSERT_NXT(a_rsp_hold, !empty && !pop, !empty && $stable(rsp_data))

   // A distance result carries no count.
   `SOM_ASSERT_IMP(a_dist_no_count, !empty && rsp_data.kind == som_pkg::KIND_DIST, rsp_data.match_count == '0)

   // A count result carries no distance and counts at least this win.
   `SOM_ASSERT_IMP(a_count_no_dist, !empty && rsp_data.kind == som_pkg::KIND_COUNT, rsp_data.distance == '0)
   `SOM_ASSERT_IMP(a_count_nonzero, !empty && rsp_data.kind == som_pkg::KIND_COUNT, rsp_data.match_count != '0)

endmodule

bind som_prototype_node_unit som_checker u_som_checker (.*);
